### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the bit sequence concatenate RTL
// Clocked checks, disabled while the asynchronous reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define BSC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define BSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Widths, register indexes and the queue item type of the bit packer.
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int WORD_BITS = 64;
	localparam int WORD_SH   = 6;
	localparam int MAX_BITS  = 65536;

	localparam int LEN_W = 17;
	localparam int WC_W  = $clog2(MAX_BITS / WORD_BITS + 1);
	localparam int TC_W  = $clog2(2 * (MAX_BITS / WORD_BITS) + 1);
	localparam int NB_W  = WORD_SH + 1;

	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_LEN  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_LEN = CFG_IDX_W'(1);

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// one classified input word
	typedef struct packed {
		logic [WORD_BITS-1:0] word;   // masked to its valid bits
		logic [NB_W-1:0]      nbits;  // 1 .. 64
		logic                 last;   // final word of the frame
		logic                 clr;    // frame overrun: clear packer state
	} item_t;

endpackage

### sv/bsc_front.sv
// ----------------------------------------------------------------------------
// bsc_front
// Holds the length registers, counts input words and classifies each word.
// ----------------------------------------------------------------------------
module bsc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsc_pkg::LEN_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bsc_pkg::WORD_BITS-1:0]     in_word,
	input  logic                              q_full,
	output logic                              q_push,
	output bsc_pkg::item_t                    q_item
);

	logic [bsc_pkg::LEN_W-1:0]     first_len_q, second_len_q;
	logic [bsc_pkg::LEN_W-1:0]     len1, len2, len_sel, sum1, sum2, rem;
	logic [bsc_pkg::WC_W-1:0]      w1, w2;
	logic [bsc_pkg::TC_W-1:0]      total, cnt_q, idx;
	logic                          in_first, drop, last, accept;
	logic [bsc_pkg::NB_W-1:0]      nbits;
	logic [bsc_pkg::WORD_BITS-1:0] mask;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= '0;
			second_len_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bsc_pkg::REG_FIRST_LEN:  first_len_q  <= cfg_data;
				bsc_pkg::REG_SECOND_LEN: second_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		len1 = (first_len_q > bsc_pkg::LEN_W'(bsc_pkg::MAX_BITS)) ?
			bsc_pkg::LEN_W'(bsc_pkg::MAX_BITS) : first_len_q;
		len2 = (second_len_q > bsc_pkg::LEN_W'(bsc_pkg::MAX_BITS)) ?
			bsc_pkg::LEN_W'(bsc_pkg::MAX_BITS) : second_len_q;
		sum1 = len1 + bsc_pkg::LEN_W'(bsc_pkg::WORD_BITS - 1);
		sum2 = len2 + bsc_pkg::LEN_W'(bsc_pkg::WORD_BITS - 1);
		w1 = sum1[bsc_pkg::LEN_W-1:bsc_pkg::WORD_SH];
		w2 = sum2[bsc_pkg::LEN_W-1:bsc_pkg::WORD_SH];
		total = bsc_pkg::TC_W'(w1) + bsc_pkg::TC_W'(w2);

		in_first = cnt_q < bsc_pkg::TC_W'(w1);
		idx      = in_first ? cnt_q : cnt_q - bsc_pkg::TC_W'(w1);
		len_sel  = in_first ? len1 : len2;
		// bits left in this sequence from this word on
		rem = len_sel - {idx[bsc_pkg::WC_W-1:0], bsc_pkg::WORD_SH'(0)};
		nbits = (rem > bsc_pkg::LEN_W'(bsc_pkg::WORD_BITS)) ?
			bsc_pkg::NB_W'(bsc_pkg::WORD_BITS) : rem[bsc_pkg::NB_W-1:0];
		mask = nbits[bsc_pkg::WORD_SH] ? '1 :
			~({bsc_pkg::WORD_BITS{1'b1}} << nbits[bsc_pkg::WORD_SH-1:0]);

		drop = cnt_q >= total;
		last = (cnt_q + bsc_pkg::TC_W'(1)) == total;

		in_stall = q_full;
		accept   = in_valid && !q_full;
		// empty frame: take the beat and drop it
		q_push       = accept && (total != '0);
		q_item.word  = in_word & mask;
		q_item.nbits = nbits;
		q_item.last  = last && !drop;
		q_item.clr   = drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (q_push) begin
			cnt_q <= (drop || last) ? '0 : cnt_q + bsc_pkg::TC_W'(1);
		end
	end

endmodule

### sv/bsc_queue.sv
// ----------------------------------------------------------------------------
// bsc_queue
// Short FIFO of classified words between the front and the packer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bsc_pkg::item_t push_item,
	output logic           full,
	output logic           head_valid,
	output bsc_pkg::item_t head_item,
	input  logic           pop
);

	bsc_pkg::item_t                entry_q [bsc_pkg::Q_DEPTH];
	logic [bsc_pkg::Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [bsc_pkg::Q_CNT_W-1:0]   cnt_q;
	logic                          do_push, do_pop;

	assign full       = cnt_q == bsc_pkg::Q_CNT_W'(bsc_pkg::Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_item  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + bsc_pkg::Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + bsc_pkg::Q_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + bsc_pkg::Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - bsc_pkg::Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`BSC_ASSERT(a_q_cnt_bound, clk, arst_n, cnt_q <= bsc_pkg::Q_CNT_W'(bsc_pkg::Q_DEPTH), "queue count past depth")
	`BSC_ASSERT_IMP(a_q_ptr_gap, clk, arst_n, cnt_q != bsc_pkg::Q_CNT_W'(bsc_pkg::Q_DEPTH), cnt_q[bsc_pkg::Q_PTR_W-1:0] == bsc_pkg::Q_PTR_W'(wr_ptr_q - rd_ptr_q), "queue pointers disagree with count")

endmodule

### sv/bsc_back.sv
// ----------------------------------------------------------------------------
// bsc_back
// Funnel-shifts queued words into the pending word and emits output beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  bsc_pkg::item_t                head_item,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bsc_pkg::WORD_BITS-1:0] out_word,
	output logic                          out_last
);

	logic [bsc_pkg::WORD_SH-1:0]   fill_q, new_fill;
	logic [bsc_pkg::WORD_BITS-1:0] bits_q, shl, carry, combined, new_bits;
	logic [bsc_pkg::NB_W-1:0]      sum;
	logic                          full_w, two_beats, one_beat, out_free;

	logic                          out_valid_q, out_last_q, extra_q;
	logic [bsc_pkg::WORD_BITS-1:0] out_word_q, extra_word_q;

	always_comb begin
		shl      = head_item.word << fill_q;
		// upper part of the word that spills past the current fill
		carry    = (fill_q == '0) ? '0 : ((head_item.word >> 1) >> (~fill_q));
		combined = bits_q | shl;
		sum      = bsc_pkg::NB_W'(fill_q) + head_item.nbits;
		full_w   = sum[bsc_pkg::WORD_SH];
		new_fill = sum[bsc_pkg::WORD_SH-1:0];
		new_bits = full_w ? carry : combined;

		two_beats = !head_item.clr && full_w && head_item.last && (new_fill != '0);
		one_beat  = !head_item.clr && (full_w || head_item.last);

		out_free = !out_valid_q || !out_stall;
		pop      = out_free && !extra_q && head_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			extra_q     <= 1'b0;
			fill_q      <= '0;
			bits_q      <= '0;
		end else if (out_free) begin
			if (extra_q) begin
				// send the flushed tail beat
				out_valid_q <= 1'b1;
				extra_q     <= 1'b0;
			end else if (head_valid) begin
				out_valid_q <= one_beat;
				extra_q     <= two_beats;
				if (head_item.clr || head_item.last) begin
					fill_q <= '0;
					bits_q <= '0;
				end else begin
					fill_q <= new_fill;
					bits_q <= new_bits;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (extra_q) begin
				out_word_q <= extra_word_q;
				out_last_q <= 1'b1;
			end else if (head_valid) begin
				out_word_q   <= combined;
				out_last_q   <= head_item.last && !two_beats;
				extra_word_q <= new_bits;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_last  = out_last_q;

	`BSC_ASSERT_IMP(a_extra_needs_out, clk, arst_n, extra_q, out_valid_q, "tail beat held without a current beat")
	`BSC_ASSERT_IMP(a_fill_zero_clean, clk, arst_n, fill_q == '0, bits_q == '0, "pending bits set with zero fill")
	`BSC_ASSERT_IMP(a_no_pop_on_tail, clk, arst_n, extra_q, !pop, "queue popped while tail beat pending")

endmodule

### sv/bit_sequence_concatenate.sv
// ----------------------------------------------------------------------------
// bit_sequence_concatenate
// Joins two LSB-first bit sequences, given as 64-bit words, into one stream.
//
//   channel  handshake           payload
//   cfg      cfg_valid/ready     cfg_index, cfg_data (lengths in bits)
//   in       in_valid/in_stall   in_word
//   out      out_valid/stall     out_word, out_last
//
// One input word per cycle while in_stall is low; a frame's last word may add a
// second output beat, which holds the queue while the output register sends it.
// An input beat passes through the queue entry and then the output register.
// A four-entry queue lets input beats keep flowing while the output stalls.
// Reset drops any partial frame; the length registers reset to zero.
// ----------------------------------------------------------------------------
module bit_sequence_concatenate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsc_pkg::LEN_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bsc_pkg::WORD_BITS-1:0]     in_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bsc_pkg::WORD_BITS-1:0]     out_word,
	output logic                              out_last
);

	logic           q_full, q_push, q_head_valid, q_pop;
	bsc_pkg::item_t q_item, q_head;

	bsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_item)
	);

	bsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_item  (q_head),
		.pop        (q_pop)
	);

	bsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_item  (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.out_last   (out_last)
	);

endmodule

### tb/sv/bsc_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_stream_checker
// Watches the config, input and output channels of the bit packer. Tracks the
// length registers, predicts the packed output beats for every accepted input
// word and compares each accepted output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module bsc_stream_checker
	import bsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [WORD_BITS-1:0] in_word,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [WORD_BITS-1:0] out_word,
	input  logic                 out_last,
	output int unsigned          mismatch_count,
	output int unsigned          words_owed
);

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic                 last;
	} packed_beat_t;

	packed_beat_t         expected_beats[$];
	logic [LEN_W-1:0]     first_len;
	logic [LEN_W-1:0]     second_len;
	logic [WORD_BITS-1:0] held_bits;
	int unsigned          held_fill;
	int unsigned          words_taken;
	int unsigned          bad_beats;

	function automatic logic [WORD_BITS-1:0] low_ones(int unsigned n);
		if (n >= WORD_BITS)
			return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic int unsigned seq_words(logic [LEN_W-1:0] len);
		int unsigned clamped;
		clamped = (len > MAX_BITS) ? MAX_BITS : len;
		return (clamped + 63) / 64;
	endfunction

	task automatic drop_frame();
		held_bits   = '0;
		held_fill   = 0;
		words_taken = 0;
	endtask

	// fold one accepted input word into the packer state, queue what it emits
	task automatic pack_word(input logic [WORD_BITS-1:0] data);
		int unsigned          first_words, total, valid_bits, seq_len, seq_idx, fill;
		logic [WORD_BITS-1:0] masked, joined;
		logic                 frame_end;
		packed_beat_t         beat;
		first_words = seq_words(first_len);
		total       = first_words + seq_words(second_len);
		if (total == 0)
			return;
		// frame shrank below what was already taken: drop word, restart
		if (words_taken >= total) begin
			drop_frame();
			return;
		end
		if (words_taken < first_words) begin
			seq_len = (first_len > MAX_BITS) ? MAX_BITS : first_len;
			seq_idx = words_taken;
		end else begin
			seq_len = (second_len > MAX_BITS) ? MAX_BITS : second_len;
			seq_idx = words_taken - first_words;
		end
		valid_bits = seq_len - (seq_idx << 6);
		if (valid_bits > 64)
			valid_bits = 64;
		masked    = data & low_ones(valid_bits);
		fill      = held_fill;
		joined    = held_bits | (masked << fill);
		frame_end = (words_taken + 1 == total);
		if (fill + valid_bits >= 64) begin
			held_bits = (fill == 0) ? '0 : (masked >> (64 - fill));
			held_fill = fill + valid_bits - 64;
			beat.word = joined;
			beat.last = frame_end && (held_fill == 0);
			expected_beats.push_back(beat);
		end else begin
			held_bits = joined;
			held_fill = fill + valid_bits;
		end
		words_taken++;
		if (frame_end) begin
			// flush the partial tail word
			if (held_fill != 0) begin
				beat.word = held_bits & low_ones(held_fill);
				beat.last = 1'b1;
				expected_beats.push_back(beat);
			end
			drop_frame();
		end
	endtask

	task automatic check_beat();
		packed_beat_t want;
		if (expected_beats.size() == 0) begin
			bad_beats++;
			if (bad_beats <= 10)
				$display("%0t: unexpected output beat word=%h last=%b",
					$realtime, out_word, out_last);
			return;
		end
		want = expected_beats.pop_front();
		if (want.word !== out_word || want.last !== out_last) begin
			bad_beats++;
			if (bad_beats <= 10)
				$display("%0t: output mismatch: expected word=%h last=%b, got word=%h last=%b",
					$realtime, want.word, want.last, out_word, out_last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_beats.delete();
			first_len  = '0;
			second_len = '0;
			drop_frame();
			bad_beats = 0;
			mismatch_count <= 0;
			words_owed     <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FIRST_LEN:  first_len  = cfg_data;
					REG_SECOND_LEN: second_len = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				check_beat();
			if (in_valid && !in_stall)
				pack_word(in_word);
			mismatch_count <= bad_beats;
			words_owed     <= expected_beats.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the bit packer with directed frames and then random frames of two
// bit sequences, reprogramming the lengths between frames while idle, with
// random gaps and stalls on both sides and long output hold-offs. The checker
// beside the block predicts and compares every output beat.
// ----------------------------------------------------------------------------
module tb_top;
	import bsc_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int STUCK_LIMIT   = 4000;
	localparam int RANDOM_WORDS  = 650;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [WORD_BITS-1:0] in_word;
	logic                 out_valid;
	logic                 out_stall;
	logic [WORD_BITS-1:0] out_word;
	logic                 out_last;

	int unsigned mismatch_count;
	int unsigned words_owed;
	int unsigned stuck_cycles;
	int          hold_req;
	int          hold_done;
	bit          hold_on;
	bit          quiet_in;

	bit_sequence_concatenate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.out_last  (out_last)
	);

	bsc_stream_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_word        (in_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_word       (out_word),
		.out_last       (out_last),
		.mismatch_count (mismatch_count),
		.words_owed     (words_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned frame_words(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
		int unsigned ca, cb;
		ca = (a > MAX_BITS) ? MAX_BITS : a;
		cb = (b > MAX_BITS) ? MAX_BITS : b;
		return (ca + 63) / 64 + (cb + 63) / 64;
	endfunction

	function automatic logic [WORD_BITS-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] rand_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 30)
			return LEN_W'($urandom_range(1, 64));
		if (r < 60)
			return LEN_W'($urandom_range(65, 256));
		if (r < 75)
			return LEN_W'(64 * $urandom_range(1, 6));
		if (r < 90)
			return LEN_W'($urandom_range(257, 900));
		return LEN_W'(64 * $urandom_range(1, 8) + $urandom_range(0, 2) - 1);
	endfunction

	// offer one beat, hold it until taken, then maybe idle
	task automatic send_word(input logic [WORD_BITS-1:0] w);
		int unsigned r, gap;
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		r   = $urandom_range(0, 99);
		gap = 0;
		if (!quiet_in) begin
			if (r >= 94)
				gap = $urandom_range(8, 40);
			else if (r >= 70)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait until every predicted beat has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_lengths(input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] b);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FIRST_LEN;
		cfg_data  <= a;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_SECOND_LEN;
		cfg_data  <= b;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// output side: random stalls, quiet runs and requested long hold-offs
	initial begin : receiver
		int unsigned r, len;
		out_stall = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req != hold_done) begin
				hold_on = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_on = 1'b0;
				hold_done++;
				@(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(60, 150)) @(posedge clk);
				end else begin
					if (r < 20)
						len = $urandom_range(20, 60);
					else if (r < 55)
						len = $urandom_range(1, 3);
					else
						len = 0;
					if (len > 0) begin
						out_stall <= 1'b1;
						repeat (len) @(posedge clk);
					end
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 10)) @(posedge clk);
				end
			end
		end
	end

	// end the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (in_valid && !in_stall)
				|| (out_valid && !out_stall))
			stuck_cycles <= 0;
		else if (stuck_cycles == STUCK_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin : stimulus
		logic [LEN_W-1:0] len_a, len_b;
		int unsigned      items, frame_no, nw, reps, cnt;
		bit               broken;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FIRST_LEN;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_word   = '0;
		hold_req  = 0;
		hold_done = 0;
		quiet_in  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both lengths still zero: words are ignored
		send_word('1);
		send_word('0);
		drain_results();
		// whole words pass straight through
		set_lengths(LEN_W'(64), LEN_W'(64));
		send_word('1);
		send_word('0);
		drain_results();
		// one valid bit per sequence, the rest discarded
		set_lengths(LEN_W'(1), LEN_W'(1));
		send_word('1);
		send_word('1);
		drain_results();
		// odd fill makes the second sequence straddle word boundaries
		set_lengths(LEN_W'(63), LEN_W'(65));
		repeat (3) send_word(rand_word());
		drain_results();
		set_lengths('0, LEN_W'(100));
		repeat (2) send_word(rand_word());
		drain_results();
		// oversized lengths clamp; hold the output so the input backs up
		set_lengths('1, '1);
		quiet_in = 1'b1;
		hold_req++;
		wait (hold_on);
		repeat (12) send_word(rand_word());
		quiet_in = 1'b0;
		drain_results();
		// shrink the frame under the words already taken: next word dropped
		set_lengths(LEN_W'(64), '0);
		send_word(rand_word());
		send_word(rand_word());
		drain_results();

		items    = 0;
		frame_no = 0;
		while (items < RANDOM_WORDS) begin
			len_a  = rand_len();
			len_b  = rand_len();
			broken = ($urandom_range(0, 9) == 0);
			if (broken && $urandom_range(0, 3) == 0)
				len_a = LEN_W'($urandom_range(MAX_BITS + 1, (1 << LEN_W) - 1));
			if (frame_no % 40 == 20) begin
				len_a  = LEN_W'(640);
				len_b  = LEN_W'(513);
				broken = 1'b0;
			end
			set_lengths(len_a, len_b);
			quiet_in = ($urandom_range(0, 3) == 0) || (frame_no % 40 == 20);
			if (frame_no % 40 == 20) begin
				hold_req++;
				wait (hold_on);
			end
			nw = frame_words(len_a, len_b);
			if (nw == 0) begin
				repeat (2) send_word(rand_word());
			end else begin
				reps = broken ? 1 : $urandom_range(1, 3);
				repeat (reps) begin
					cnt = broken ? $urandom_range(0, (nw - 1 < 20) ? nw - 1 : 20) : nw;
					repeat (cnt) send_word(rand_word());
					items += cnt;
				end
			end
			drain_results();
			// cut a frame short, then resync with a one-word frame
			if (broken) begin
				set_lengths(LEN_W'(64), '0);
				send_word(rand_word());
				drain_results();
			end
			frame_no++;
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && words_owed == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
